// ===== hw/rtl/rvq_pkg.sv =====
`default_nettype none
package rvq_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH_DEF = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 31;
  localparam int TW           = 36;

  localparam logic signed [TW-1:0] Q30_PI          = 36'sd3373259426;
  localparam logic signed [TW-1:0] Q30_HALF_PI     = 36'sd1686629713;
  localparam logic signed [TW-1:0] Q30_TWO_PI      = 36'sd6746518852;
  localparam logic signed [TW-1:0] CORDIC_GAIN_INV = 36'sd652032874;

  // atan(2^-i) in Q2.30; from step 10 on it equals 2^(30-i)
  function automatic logic signed [TW-1:0] atan_q30(input int idx);
    logic signed [TW-1:0] v;
    unique case (idx)
      0: v = 36'sd843314857;
      1: v = 36'sd497837829;
      2: v = 36'sd263043837;
      3: v = 36'sd133525159;
      4: v = 36'sd67021687;
      5: v = 36'sd33543516;
      6: v = 36'sd16775851;
      7: v = 36'sd8388437;
      8: v = 36'sd4194283;
      9: v = 36'sd2097149;
      default: v = TW'(1) <<< (30 - idx);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rvq_if.sv =====
`default_nettype none
interface rvq_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] rot_x;
  logic [W-1:0] rot_y;
  logic [W-1:0] rot_z;
  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

interface rvq_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] quat_x;
  logic [W-1:0] quat_y;
  logic [W-1:0] quat_z;
  logic [W-1:0] quat_w;
  logic         zero_angle;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, zero_angle, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, zero_angle, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rvq_sqrt_cell.sv =====
`default_nettype none
module rvq_sqrt_cell #(
  parameter int SW     = 32,
  parameter int RW     = 16,
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SW:0]       rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [SW:0]       rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q;
  logic [SW:0]       rem_q, rem_d;
  logic [RW-1:0]     root_q, root_d;
  logic [SIDE_W-1:0] side_q;
  logic [SW:0]       trial;

  always_comb begin
    trial = (((SW+1)'(root_i)) << (BIT + 1)) + ((SW+1)'(1) << (2 * BIT));
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = root_i | (RW'(1) << BIT);
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rvq_trig_cell.sv =====
`default_nettype none
module rvq_trig_cell import rvq_pkg::*; #(
  parameter int IDX    = 0,
  parameter int AW     = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [TW-1:0] cx_i,
  input  logic signed [TW-1:0] cy_i,
  input  logic signed [TW-1:0] cz_i,
  input  logic [AW-1:0]        angle_i,
  input  logic [AW:0]          rem_i [3],
  input  logic [DIV_STEPS-1:0] q_i [3],
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic signed [TW-1:0] cx_o,
  output logic signed [TW-1:0] cy_o,
  output logic signed [TW-1:0] cz_o,
  output logic [AW-1:0]        angle_o,
  output logic [AW:0]          rem_o [3],
  output logic [DIV_STEPS-1:0] q_o [3],
  output logic [SIDE_W-1:0]    side_o
);

  localparam int SHL = (IDX == 0) ? 0 : 1;

  logic                 valid_q;
  logic signed [TW-1:0] cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [AW-1:0]        angle_q;
  logic [AW:0]          rem_q [3];
  logic [AW:0]          rem_d [3];
  logic [DIV_STEPS-1:0] q_q [3];
  logic [DIV_STEPS-1:0] q_d [3];
  logic [SIDE_W-1:0]    side_q;

  // one restoring-division quotient bit per lane
  always_comb begin
    logic [AW:0] t;
    logic        ge;
    for (int l = 0; l < 3; l++) begin
      t        = rem_i[l] << SHL;
      ge       = t >= {1'b0, angle_i};
      rem_d[l] = ge ? t - {1'b0, angle_i} : t;
      q_d[l]   = {q_i[l][DIV_STEPS-2:0], ge};
    end
  end

  if (IDX < CORDIC_STEPS) begin : g_rot
    localparam logic signed [TW-1:0] AT = atan_q30(IDX);
    logic signed [TW-1:0] dx, dy;
    assign dx = cy_i >>> IDX;
    assign dy = cx_i >>> IDX;
    always_comb begin
      if (!cz_i[TW-1]) begin
        cx_d = cx_i - dx;
        cy_d = cy_i + dy;
        cz_d = cz_i - AT;
      end else begin
        cx_d = cx_i + dx;
        cy_d = cy_i - dy;
        cz_d = cz_i + AT;
      end
    end
  end else begin : g_pass
    assign cx_d = cx_i;
    assign cy_d = cy_i;
    assign cz_d = cz_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      cz_q    <= cz_d;
      angle_q <= angle_i;
      side_q  <= side_i;
      for (int l = 0; l < 3; l++) begin
        rem_q[l] <= rem_d[l];
        q_q[l]   <= q_d[l];
      end
    end
  end

  assign valid_o = valid_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign cz_o    = cz_q;
  assign angle_o = angle_q;
  assign rem_o   = rem_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rotation_vector_to_quaternion.sv =====
`default_nettype none
// Rotation vector (Q3.12 radians at the default width) to unit quaternion (Q1.14).
// Fully pipelined: one vector per cycle while out_o.ready is not held low (one input
// stage, one square-root cell per root bit, a range-reduction stage, 31 cells that
// each do one quotient bit of the three divisions, with a CORDIC step in the first 30,
// a multiply stage and the output register). Each stage holds its beat until the next
// one can take it, so a stalled output only blocks input once every stage is full.
// A zero vector gives the identity quaternion with zero_angle set.
module rotation_vector_to_quaternion import rvq_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvq_in_if.sink     in_i,
  rvq_out_if.source  out_o
);

  localparam int SW     = 2 * IN_WIDTH;
  localparam int AW     = IN_WIDTH;
  localparam int IN_FRAC = IN_WIDTH - 4;
  localparam int F      = OUT_WIDTH - 2;
  localparam int TH_SH  = 29 - IN_FRAC;
  localparam int VSH    = 60 - F;
  localparam int WSH    = 30 - F;
  localparam int NSQ    = IN_WIDTH;
  localparam int NTR    = DIV_STEPS;
  localparam int SIDE_A = 3 + 3 * IN_WIDTH;
  localparam int SIDE_T = 5;
  localparam int PW     = 63;

  localparam logic [PW-1:0]        ONE_P  = PW'(1) << F;
  localparam logic [TW-1:0]        ONE_T  = TW'(1) << F;
  localparam logic [OUT_WIDTH-1:0] ONE_O  = OUT_WIDTH'(1) << F;

  // input stage: magnitudes and sum of squares
  logic                v_a_q, adv_a;
  logic [SW-1:0]       a_sum_q;
  logic [SIDE_A-1:0]   a_side_q;
  logic [IN_WIDTH-1:0] mx, my, mz;

  assign mx = in_i.rot_x[IN_WIDTH-1] ? IN_WIDTH'(0) - in_i.rot_x : in_i.rot_x;
  assign my = in_i.rot_y[IN_WIDTH-1] ? IN_WIDTH'(0) - in_i.rot_y : in_i.rot_y;
  assign mz = in_i.rot_z[IN_WIDTH-1] ? IN_WIDTH'(0) - in_i.rot_z : in_i.rot_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else if (adv_a) begin
      v_a_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_sum_q  <= SW'(mx) * SW'(mx) + SW'(my) * SW'(my) + SW'(mz) * SW'(mz);
      a_side_q <= {in_i.rot_x[IN_WIDTH-1], in_i.rot_y[IN_WIDTH-1],
                   in_i.rot_z[IN_WIDTH-1], mx, my, mz};
    end
  end

  // square-root cells
  logic                s_v    [NSQ+1];
  logic                s_adv  [NSQ];
  logic [SW:0]         s_rem  [NSQ+1];
  logic [AW-1:0]       s_root [NSQ+1];
  logic [SIDE_A-1:0]   s_side [NSQ+1];
  logic                adv_r;

  assign s_v[0]    = v_a_q;
  assign s_rem[0]  = {1'b0, a_sum_q};
  assign s_root[0] = '0;
  assign s_side[0] = a_side_q;

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    if (k == NSQ - 1) begin : g_last
      assign s_adv[k] = !s_v[k+1] || adv_r;
    end else begin : g_mid
      assign s_adv[k] = !s_v[k+1] || s_adv[k+1];
    end
    rvq_sqrt_cell #(
      .SW(SW), .RW(AW), .BIT(NSQ - 1 - k), .SIDE_W(SIDE_A)
    ) u_cell (
      .clk_i, .rst_ni,
      .en_i(s_adv[k]), .valid_i(s_v[k]),
      .rem_i(s_rem[k]), .root_i(s_root[k]), .side_i(s_side[k]),
      .valid_o(s_v[k+1]), .rem_o(s_rem[k+1]), .root_o(s_root[k+1]),
      .side_o(s_side[k+1])
    );
  end

  assign adv_a = !v_a_q || s_adv[0];

  // range reduction of the half angle
  logic                 v_r_q;
  logic signed [TW-1:0] th0, th1, r_cz_d, r_cz_q;
  logic                 r_flip_d, r_flip_q, r_zero_q;
  logic [AW-1:0]        r_angle_q;
  logic [AW:0]          r_rem_q [3];
  logic [2:0]           r_neg_q;
  logic [SIDE_A-1:0]    sq_side;
  logic [AW-1:0]        sq_root;
  logic                 t_v    [NTR+1];
  logic                 t_adv  [NTR];

  assign sq_side = s_side[NSQ];
  assign sq_root = s_root[NSQ];
  assign th0     = signed'(TW'(sq_root) << TH_SH);
  assign th1     = (th0 > Q30_PI) ? th0 - Q30_TWO_PI : th0;

  always_comb begin
    if (th1 > Q30_HALF_PI) begin
      r_cz_d   = Q30_PI - th1;
      r_flip_d = 1'b1;
    end else if (th1 < -Q30_HALF_PI) begin
      r_cz_d   = -Q30_PI - th1;
      r_flip_d = 1'b1;
    end else begin
      r_cz_d   = th1;
      r_flip_d = 1'b0;
    end
  end

  assign adv_r = !v_r_q || t_adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_r_q <= 1'b0;
    end else if (adv_r) begin
      v_r_q <= s_v[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_r) begin
      r_cz_q     <= r_cz_d;
      r_flip_q   <= r_flip_d;
      r_zero_q   <= sq_root == '0;
      r_angle_q  <= sq_root;
      r_neg_q    <= sq_side[SIDE_A-1 -: 3];
      r_rem_q[0] <= {1'b0, sq_side[3*IN_WIDTH-1 -: IN_WIDTH]};
      r_rem_q[1] <= {1'b0, sq_side[2*IN_WIDTH-1 -: IN_WIDTH]};
      r_rem_q[2] <= {1'b0, sq_side[IN_WIDTH-1:0]};
    end
  end

  // CORDIC and division cells
  logic signed [TW-1:0] t_cx [NTR+1];
  logic signed [TW-1:0] t_cy [NTR+1];
  logic signed [TW-1:0] t_cz [NTR+1];
  logic [AW-1:0]        t_angle [NTR+1];
  logic [AW:0]          t_rem [NTR+1][3];
  logic [DIV_STEPS-1:0] t_q   [NTR+1][3];
  logic [SIDE_T-1:0]    t_side [NTR+1];
  logic                 adv_m;

  assign t_v[0]     = v_r_q;
  assign t_cx[0]    = CORDIC_GAIN_INV;
  assign t_cy[0]    = '0;
  assign t_cz[0]    = r_cz_q;
  assign t_angle[0] = r_angle_q;
  assign t_rem[0]   = r_rem_q;
  assign t_q[0][0]  = '0;
  assign t_q[0][1]  = '0;
  assign t_q[0][2]  = '0;
  assign t_side[0]  = {r_neg_q, r_flip_q, r_zero_q};

  for (genvar k = 0; k < NTR; k++) begin : g_tr
    if (k == NTR - 1) begin : g_last
      assign t_adv[k] = !t_v[k+1] || adv_m;
    end else begin : g_mid
      assign t_adv[k] = !t_v[k+1] || t_adv[k+1];
    end
    rvq_trig_cell #(
      .IDX(k), .AW(AW), .SIDE_W(SIDE_T)
    ) u_cell (
      .clk_i, .rst_ni,
      .en_i(t_adv[k]), .valid_i(t_v[k]),
      .cx_i(t_cx[k]), .cy_i(t_cy[k]), .cz_i(t_cz[k]), .angle_i(t_angle[k]),
      .rem_i(t_rem[k]), .q_i(t_q[k]), .side_i(t_side[k]),
      .valid_o(t_v[k+1]),
      .cx_o(t_cx[k+1]), .cy_o(t_cy[k+1]), .cz_o(t_cz[k+1]), .angle_o(t_angle[k+1]),
      .rem_o(t_rem[k+1]), .q_o(t_q[k+1]), .side_o(t_side[k+1])
    );
  end

  // multiply stage
  logic                 v_m_q, adv_o;
  logic [PW-1:0]        m_prod_q [3];
  logic [2:0]           m_vneg_q;
  logic                 m_wneg_q, m_zero_q;
  logic [TW-1:0]        m_mw_q;
  logic signed [TW-1:0] cy_f, cx_f;
  logic [TW-1:0]        cy_abs;
  logic [31:0]          ms;
  logic [SIDE_T-1:0]    tr_side;

  assign tr_side = t_side[NTR];
  assign cy_f    = t_cy[NTR];
  assign cx_f    = tr_side[1] ? -t_cx[NTR] : t_cx[NTR];
  assign cy_abs  = cy_f[TW-1] ? TW'(-cy_f) : TW'(cy_f);
  assign ms      = (cy_abs > (TW'(1) << 31)) ? 32'h8000_0000 : cy_abs[31:0];
  assign adv_m   = !v_m_q || adv_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_m_q <= 1'b0;
    end else if (adv_m) begin
      v_m_q <= t_v[NTR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_m) begin
      for (int l = 0; l < 3; l++) begin
        m_prod_q[l] <= PW'(t_q[NTR][l]) * PW'(ms);
        m_vneg_q[l] <= tr_side[4-l] ^ cy_f[TW-1];
      end
      m_wneg_q <= cx_f[TW-1];
      m_mw_q   <= cx_f[TW-1] ? TW'(-cx_f) : TW'(cx_f);
      m_zero_q <= tr_side[0];
    end
  end

  // rounding, saturation and output register
  logic                 v_o_q;
  logic [OUT_WIDTH-1:0] o_v_q [3];
  logic [OUT_WIDTH-1:0] o_w_q;
  logic                 o_zero_q;
  logic [OUT_WIDTH-1:0] v_fld [3];
  logic [OUT_WIDTH-1:0] w_fld;
  logic [TW-1:0]        mw_r, mw_s;

  always_comb begin
    logic [PW-1:0] r;
    for (int l = 0; l < 3; l++) begin
      r        = (m_prod_q[l] + (PW'(1) << (VSH - 1))) >> VSH;
      if (r > ONE_P) r = ONE_P;
      v_fld[l] = m_vneg_q[l] ? OUT_WIDTH'(0) - OUT_WIDTH'(r) : OUT_WIDTH'(r);
    end
  end

  if (WSH > 0) begin : g_wround
    assign mw_r = (m_mw_q + (TW'(1) << (WSH - 1))) >> WSH;
  end else begin : g_wexact
    assign mw_r = m_mw_q;
  end

  assign mw_s  = (mw_r > ONE_T) ? ONE_T : mw_r;
  assign w_fld = m_wneg_q ? OUT_WIDTH'(0) - OUT_WIDTH'(mw_s) : OUT_WIDTH'(mw_s);
  assign adv_o = !v_o_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o_q <= 1'b0;
    end else if (adv_o) begin
      v_o_q <= v_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      for (int l = 0; l < 3; l++) begin
        o_v_q[l] <= m_zero_q ? '0 : v_fld[l];
      end
      o_w_q    <= m_zero_q ? ONE_O : w_fld;
      o_zero_q <= m_zero_q;
    end
  end

  assign in_i.ready       = adv_a;
  assign out_o.valid      = v_o_q;
  assign out_o.quat_x     = o_v_q[0];
  assign out_o.quat_y     = o_v_q[1];
  assign out_o.quat_z     = o_v_q[2];
  assign out_o.quat_w     = o_w_q;
  assign out_o.zero_angle = o_zero_q;

`ifndef SYNTHESIS
  a_zero_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_angle |->
      out_o.quat_w == ONE_O && out_o.quat_x == '0 && out_o.quat_y == '0 &&
      out_o.quat_z == '0)
    else $error("zero vector did not give identity");

  a_ready_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> v_a_q)
    else $error("input stalled while input stage is empty");

  a_out_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_m_q && !v_o_q |=> v_o_q)
    else $error("beat lost between multiply stage and output");
`endif

endmodule
`default_nettype wire
